// ===== design/pnc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnc_pkg: shared types, codes and helpers of the palette color matcher
// Operation codes, register indexes, distance width and the RGB565 to
// RGB888 channel expansion.
// ----------------------------------------------------------------------------
package pnc_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_CART    = 2'd0,
      OP_WRITE_OVERLAY = 2'd1,
      OP_MATCH         = 2'd2,
      OP_NONE          = 2'd3
   } op_type;

   localparam logic [1:0] REG_PALETTE_MODE  = 2'd0;
   localparam logic [1:0] REG_CART_COUNT    = 2'd1;
   localparam logic [1:0] REG_OVERLAY_COUNT = 2'd2;

   // Three squared 8-bit differences sum to at most 195075.
   localparam int DIST_W = 18;

   typedef logic [DIST_W-1:0] dist_type;

   // floor(v * 255 / 31) = 8v + floor(7v / 31), the second term counted by compares.
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0] t;
      logic [2:0] q;
      t = 8'(v) * 8'd7;
      q = 3'(t >= 8'd31) + 3'(t >= 8'd62) + 3'(t >= 8'd93) + 3'(t >= 8'd124)
        + 3'(t >= 8'd155) + 3'(t >= 8'd186) + 3'(t >= 8'd217);
      return {v, 3'b000} + 8'(q);
   endfunction

   // floor(v * 255 / 63) = 4v + floor(v / 21).
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] q;
      q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      return {v, 2'b00} + 8'(q);
   endfunction

endpackage
`default_nettype wire

// ===== design/palette_nearest_color_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palette_nearest_color_match: nearest palette color search for RGB565 pixels
// Holds cart and overlay palette entries and returns the index of the entry
// closest to each query color in squared RGB distance.
// ----------------------------------------------------------------------------
// A match transfer passes the query stage, the distance lanes, the LEVELS levels
// of the minimum tree and the result register before the result strobe rises,
// where LEVELS is the depth of the minimum tree (5 with 32 cart entries).
// Throughput: one item per cycle; busy never rises, and entry writes give no result.
// The result strobe cannot be held off, so the pipeline never stops.
// Reset clears the configuration registers and all valid bits; palette entries are
// undefined until written.
module palette_nearest_color_match
   import pnc_pkg::*;
#(
   parameter int CART_ENTRIES    = 32,
   parameter int OVERLAY_ENTRIES = 4,
   parameter int OVERLAY_BASE    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [4:0]  req_entry_index,
   input  wire logic [23:0] req_entry_color,
   input  wire logic [15:0] req_query_color,
   output      logic        rsp_valid,
   output      logic [15:0] rsp_packed_value,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_write_data
);

   // Tree depth is set by the larger of the two palettes so both trees line up.
   localparam int LC     = (CART_ENTRIES > 1) ? $clog2(CART_ENTRIES) : 0;
   localparam int LO     = (OVERLAY_ENTRIES > 1) ? $clog2(OVERLAY_ENTRIES) : 0;
   localparam int LEVELS = (LC > LO) ? LC : LO;
   localparam int IW     = (LEVELS > 0) ? LEVELS : 1;
   localparam int CAW    = (CART_ENTRIES > 1) ? $clog2(CART_ENTRIES) : 1;
   localparam int OAW    = (OVERLAY_ENTRIES > 1) ? $clog2(OVERLAY_ENTRIES) : 1;

   // The block takes a transfer in every cycle.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Configuration registers.
   logic       mode_ff;
   logic [5:0] cart_cnt_ff;
   logic [2:0] ovl_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         cart_cnt_ff <= '0;
         ovl_cnt_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PALETTE_MODE:  mode_ff     <= csr_write_data[0];
            REG_CART_COUNT:    cart_cnt_ff <= csr_write_data;
            REG_OVERLAY_COUNT: ovl_cnt_ff  <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // Palette storage. Every entry feeds its own distance lane, so the entries
   // are plain registers. A write in palette mode off is dropped for cart slots.
   logic [CART_ENTRIES-1:0][23:0]    cart_tab_ff;
   logic [OVERLAY_ENTRIES-1:0][23:0] ovl_tab_ff;

   always_ff @(posedge clock) begin
      if (accept && op_type'(req_operation) == OP_WRITE_CART && mode_ff &&
          32'(req_entry_index) < CART_ENTRIES) begin
         cart_tab_ff[CAW'(req_entry_index)] <= req_entry_color;
      end
      if (accept && op_type'(req_operation) == OP_WRITE_OVERLAY &&
          32'(req_entry_index) < OVERLAY_ENTRIES) begin
         ovl_tab_ff[OAW'(req_entry_index)] <= req_entry_color;
      end
   end

   // Stage 1: expand the query to RGB888 and note the special cases.
   logic        s1_vld_ff;
   logic        s1_mode_ff;
   logic        s1_zero_ff;
   logic [15:0] s1_query_ff;
   logic [7:0]  s1_red_ff, s1_green_ff, s1_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept && op_type'(req_operation) == OP_MATCH;
      end
      s1_mode_ff  <= mode_ff;
      s1_zero_ff  <= (cart_cnt_ff == '0) && (ovl_cnt_ff == '0);
      s1_query_ff <= req_query_color;
      s1_red_ff   <= expand5(req_query_color[15:11]);
      s1_green_ff <= expand6(req_query_color[10:5]);
      s1_blue_ff  <= expand5(req_query_color[4:0]);
   end

   // Lane enables. A count above the palette size enables every lane,
   // which gives the saturation for free.
   logic [CART_ENTRIES-1:0]    cart_act;
   logic [OVERLAY_ENTRIES-1:0] ovl_act;

   always_comb begin
      for (int i = 0; i < CART_ENTRIES; i++) begin
         cart_act[i] = 32'(cart_cnt_ff) > i;
      end
      for (int i = 0; i < OVERLAY_ENTRIES; i++) begin
         ovl_act[i] = 32'(ovl_cnt_ff) > i;
      end
   end

   // Stage 2: distance lanes. The palette is read while the match sits in
   // stage 1, so a write that follows the match cannot affect it.
   dist_type [CART_ENTRIES-1:0]    cart_dist;
   dist_type [OVERLAY_ENTRIES-1:0] ovl_dist;
   logic [CART_ENTRIES-1:0]        cart_lane_act;
   logic [OVERLAY_ENTRIES-1:0]     ovl_lane_act;

   pnc_dist_lanes #(.N(CART_ENTRIES)) u_cart_lanes (
      .clock       (clock),
      .red         (s1_red_ff),
      .green       (s1_green_ff),
      .blue        (s1_blue_ff),
      .entries     (cart_tab_ff),
      .lane_active (cart_act),
      .dist_ff     (cart_dist),
      .active_ff   (cart_lane_act)
   );

   pnc_dist_lanes #(.N(OVERLAY_ENTRIES)) u_ovl_lanes (
      .clock       (clock),
      .red         (s1_red_ff),
      .green       (s1_green_ff),
      .blue        (s1_blue_ff),
      .entries     (ovl_tab_ff),
      .lane_active (ovl_act),
      .dist_ff     (ovl_dist),
      .active_ff   (ovl_lane_act)
   );

   // Stages 3 and on: one tree level per stage for each palette.
   logic          cart_found, ovl_found;
   dist_type      cart_best, ovl_best;
   logic [IW-1:0] cart_idx, ovl_idx;

   pnc_min_tree #(.N(CART_ENTRIES), .LEVELS(LEVELS), .IW(IW)) u_cart_tree (
      .clock       (clock),
      .leaf_active (cart_lane_act),
      .leaf_dist   (cart_dist),
      .best_found  (cart_found),
      .root_dist   (cart_best),
      .root_slot   (cart_idx)
   );

   pnc_min_tree #(.N(OVERLAY_ENTRIES), .LEVELS(LEVELS), .IW(IW)) u_ovl_tree (
      .clock       (clock),
      .leaf_active (ovl_lane_act),
      .leaf_dist   (ovl_dist),
      .best_found  (ovl_found),
      .root_dist   (ovl_best),
      .root_slot   (ovl_idx)
   );

   // Side line that carries the match's control alongside the lanes and tree.
   logic        ln_vld_ff   [LEVELS+1];
   logic        ln_mode_ff  [LEVELS+1];
   logic        ln_zero_ff  [LEVELS+1];
   logic [15:0] ln_query_ff [LEVELS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LEVELS; s++) begin
            ln_vld_ff[s] <= 1'b0;
         end
      end else begin
         ln_vld_ff[0] <= s1_vld_ff;
         for (int s = 1; s <= LEVELS; s++) begin
            ln_vld_ff[s] <= ln_vld_ff[s-1];
         end
      end
      ln_mode_ff[0]  <= s1_mode_ff;
      ln_zero_ff[0]  <= s1_zero_ff;
      ln_query_ff[0] <= s1_query_ff;
      for (int s = 1; s <= LEVELS; s++) begin
         ln_mode_ff[s]  <= ln_mode_ff[s-1];
         ln_zero_ff[s]  <= ln_zero_ff[s-1];
         ln_query_ff[s] <= ln_query_ff[s-1];
      end
   end

   // Final stage: mode off passes the query through, both counts zero give zero,
   // and else the overlay winner keeps a tie against the cart winner.
   logic        ovl_wins;
   logic [7:0]  ovl_code;
   logic [15:0] packed_in;

   always_comb begin
      ovl_wins = ovl_found && (!cart_found || ovl_best <= cart_best);
      ovl_code = 8'(OVERLAY_BASE) + 8'(ovl_idx);
      if (!ln_mode_ff[LEVELS]) begin
         packed_in = ln_query_ff[LEVELS];
      end else if (ln_zero_ff[LEVELS]) begin
         packed_in = '0;
      end else if (ovl_wins) begin
         packed_in = 16'(ovl_code);
      end else begin
         packed_in = 16'(cart_idx);
      end
   end

   logic        rsp_valid_ff;
   logic [15:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ln_vld_ff[LEVELS];
      end
      rsp_value_ff <= packed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_value = rsp_value_ff;

endmodule
`default_nettype wire

// ===== design/pnc_dist_lanes.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnc_dist_lanes: registered squared-distance lanes
// One lane per palette entry computes the squared RGB distance to the query.
// ----------------------------------------------------------------------------
module pnc_dist_lanes
   import pnc_pkg::*;
#(
   parameter int N = 4
) (
   input  wire logic                 clock,
   input  wire logic [7:0]           red,
   input  wire logic [7:0]           green,
   input  wire logic [7:0]           blue,
   input  wire logic [N-1:0][23:0]   entries,
   input  wire logic [N-1:0]         lane_active,
   output      dist_type [N-1:0]     dist_ff,
   output      logic [N-1:0]         active_ff
);

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_lane
         logic [7:0] dr, dg, db;
         logic [15:0] sr, sg, sb;
         dist_type dist_in;
         always_comb begin
            dr = (red > entries[i][23:16]) ? red - entries[i][23:16]
                                          : entries[i][23:16] - red;
            dg = (green > entries[i][15:8]) ? green - entries[i][15:8]
                                           : entries[i][15:8] - green;
            db = (blue > entries[i][7:0]) ? blue - entries[i][7:0]
                                         : entries[i][7:0] - blue;
            sr = dr * dr;
            sg = dg * dg;
            sb = db * db;
            dist_in = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
         end
         always_ff @(posedge clock) begin
            dist_ff[i]   <= dist_in;
            active_ff[i] <= lane_active[i];
         end
      end
   endgenerate

endmodule
`default_nettype wire

// ===== design/pnc_min_tree.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnc_min_tree: pipelined minimum search
// A binary tree with one register level per compare level; the lower index
// wins a tie, and inactive leaves never win.
// ----------------------------------------------------------------------------
module pnc_min_tree
   import pnc_pkg::*;
#(
   parameter int N      = 4,
   parameter int LEVELS = 2,
   parameter int IW     = 2
) (
   input  wire logic              clock,
   input  wire logic [N-1:0]      leaf_active,
   input  wire dist_type [N-1:0]  leaf_dist,
   output      logic              best_found,
   output      dist_type          root_dist,
   output      logic [IW-1:0]     root_slot
);

   localparam int P = 1 << LEVELS;

   logic          act [1:2*P-1];
   dist_type      dst [1:2*P-1];
   logic [IW-1:0] idx [1:2*P-1];

   genvar j, k;
   generate
      for (j = 0; j < P; j++) begin : g_leaf
         if (j < N) begin : g_used
            assign act[P+j] = leaf_active[j];
            assign dst[P+j] = leaf_dist[j];
         end else begin : g_pad
            assign act[P+j] = 1'b0;
            assign dst[P+j] = '0;
         end
         assign idx[P+j] = IW'(j);
      end
      for (k = 1; k < P; k++) begin : g_node
         logic take_left;
         assign take_left = act[2*k] && (!act[2*k+1] || dst[2*k] <= dst[2*k+1]);
         always_ff @(posedge clock) begin
            act[k] <= act[2*k] | act[2*k+1];
            dst[k] <= take_left ? dst[2*k] : dst[2*k+1];
            idx[k] <= take_left ? idx[2*k] : idx[2*k+1];
         end
      end
   endgenerate

   assign best_found = act[1];
   assign root_dist  = dst[1];
   assign root_slot  = idx[1];

endmodule
`default_nettype wire

// ===== design/pnc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnc_checker: port-level checks of the palette color matcher
// Watches the result strobe against accepted match transfers.
// ----------------------------------------------------------------------------
module pnc_checker
   import pnc_pkg::*;
#(
   parameter int CART_ENTRIES    = 32,
   parameter int OVERLAY_ENTRIES = 4
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [1:0]  req_operation,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_packed_value
);

   localparam int LC     = (CART_ENTRIES > 1) ? $clog2(CART_ENTRIES) : 0;
   localparam int LO     = (OVERLAY_ENTRIES > 1) ? $clog2(OVERLAY_ENTRIES) : 0;
   localparam int LEVELS = (LC > LO) ? LC : LO;
   localparam int LAT    = LEVELS + 3;

   logic match_in;
   assign match_in = start && !busy && op_type'(req_operation) == OP_MATCH;

   // Every match transfer is followed by its result strobe.
   a_match_result: assert property (@(posedge clock) disable iff (reset)
      match_in |-> ##LAT rsp_valid)
      else $error("match transfer without result");

   // No result appears without a match transfer at the right distance back.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(match_in, LAT))
      else $error("result without match transfer");

   // The result strobe is low right after a reset cycle.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe after reset");

   // A strobed result carries a fully known value.
   a_value_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_packed_value))
      else $error("unknown bits in result");

   // The pipeline never pushes back.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind palette_nearest_color_match pnc_checker #(
   .CART_ENTRIES    (CART_ENTRIES),
   .OVERLAY_ENTRIES (OVERLAY_ENTRIES)
) u_pnc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_packed_value (rsp_packed_value)
);
`default_nettype wire
